/* design/pidc_pkg.sv */
// shared types, constants and helpers for the pid step block
`default_nettype none

package pidc_pkg;

  // datapath widths
  localparam int DATA_W = 32;
  localparam int PER_W  = 31;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int FRAC_W = 16;
  localparam int HI_W   = PROD_W - FRAC_W;
  localparam int DIVD_W = 49;
  localparam int DIVS_W = 31;
  localparam int CNT_W  = 6;

  // configuration register indexes
  localparam logic [2:0] CFG_PROP_GAIN  = 3'd0;
  localparam logic [2:0] CFG_INTEG_GAIN = 3'd1;
  localparam logic [2:0] CFG_DERIV_GAIN = 3'd2;
  localparam logic [2:0] CFG_PERIOD     = 3'd3;
  localparam logic [2:0] CFG_LIMIT      = 3'd4;
  localparam logic [2:0] CFG_ENABLE     = 3'd5;
  localparam logic [2:0] CFG_HOLD       = 3'd6;

  // integrator clamp status codes
  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_HIGH = 2'd1;
  localparam logic [1:0] CLAMP_LOW  = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_EP,
    ST_STEP,
    ST_SG,
    ST_INT,
    ST_D,
    ST_SUM,
    ST_OUT
  } state_t;

  // divider request and status
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quot;
  } div_stat_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [51:0] x);
    logic signed [51:0] hi;
    logic signed [51:0] lo;
    hi = 52'sh0_0000_7FFF_FFFF;
    lo = -52'sh0_0000_8000_0000;
    if (x > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[DATA_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* design/pid_step_with_integrator_clamp.sv */
// pid controller step with integrator clamp, signed q16.16, top level
//
// Each input transfer is either a clear (tuser high) or a control step carrying
// an error sample in tdata; each produces exactly one result transfer with the
// drive in tdata[31:0] and the clamp status in tdata[33:32]. A clear or a step
// with a zero sample period goes from the idle state straight to the last state
// and from there into the output register. A control step on the first sample
// after a clear skips the divider; every later step first runs the serial divider
// that forms the derivative. Both then make four passes through the one shared
// 33x33 multiplier, followed by the final saturating add. The block takes one
// item at a time; a new item can be accepted while the previous result still
// waits in the output register, and a finished item waits in the last state
// until that register is free. Configuration writes take effect at once and
// belong only to idle periods.
`default_nettype none

module pid_step_with_integrator_clamp import pidc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] error_in
  input  wire logic        in_tuser,   // [0] kind
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [31:0] drive, [33:32] clamp_status
);

  // configuration registers
  logic signed [DATA_W-1:0] prop_gain_r;
  logic signed [DATA_W-1:0] integ_gain_r;
  logic signed [DATA_W-1:0] deriv_gain_r;
  logic [PER_W-1:0]         period_r;
  logic [PER_W-1:0]         limit_r;
  logic                     enable_r;
  logic                     hold_r;

  // controller state
  logic signed [DATA_W-1:0] last_error_r;
  logic signed [DATA_W-1:0] last_drive_r;
  logic signed [DATA_W-1:0] integral_r;
  logic                     first_r;
  logic [1:0]               clamp_flag_r;

  // working registers
  state_t                   state_r;
  state_t                   state_nxt;
  logic signed [DATA_W-1:0] err_r;
  logic signed [DATA_W-1:0] deriv_r;
  logic signed [DATA_W-1:0] step_r;
  logic                     dneg_r;
  logic signed [HI_W-1:0]   p_r;
  logic signed [HI_W:0]     pd_r;
  logic signed [DATA_W-1:0] res_drive_r;
  logic [1:0]               res_clamp_r;

  // output register
  logic                     out_tvalid_r;
  logic signed [DATA_W-1:0] out_drive_r;
  logic [1:0]               out_clamp_r;

  // shared units
  div_req_t                 div_req;
  div_stat_t                div_stat;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  // derived values
  logic                     in_xfer;
  logic signed [DATA_W-1:0] in_err;
  logic signed [DATA_W:0]   err_diff;
  logic [DATA_W:0]          diff_mag;
  logic signed [HI_W-1:0]   prod_hi;
  logic signed [DATA_W-1:0] prod_sat;
  logic signed [DATA_W-1:0] deriv_sat;
  logic signed [DATA_W:0]   integ_sum;
  logic signed [DATA_W:0]   lim_pos;
  logic signed [DATA_W:0]   lim_neg;
  logic signed [51:0]       drive_sum;
  logic                     out_free;

  pidc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat)
  );

  pidc_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // input decode and derivative numerator
  always_comb begin
    in_xfer  = in_tvalid && in_tready;
    in_err   = $signed(in_tdata);
    err_diff = $signed({in_err[DATA_W-1], in_err})
             - $signed({last_error_r[DATA_W-1], last_error_r});
    diff_mag = err_diff[DATA_W] ? $unsigned(-err_diff) : $unsigned(err_diff);
    out_free = !out_tvalid_r || out_tready;
  end

  // product back to q16.16 and saturation
  always_comb begin
    prod_hi  = prod[PROD_W-1:FRAC_W];
    prod_sat = sat32($signed({{(52 - HI_W){prod_hi[HI_W-1]}}, prod_hi}));
  end

  // signed saturated derivative from the divider magnitude
  always_comb begin
    if (dneg_r) begin
      if (div_stat.quot > DIVD_W'(64'h8000_0000)) begin
        deriv_sat = 32'sh8000_0000;
      end else begin
        deriv_sat = -$signed(div_stat.quot[DATA_W-1:0]);
      end
    end else if (div_stat.quot > DIVD_W'(64'h7FFF_FFFF)) begin
      deriv_sat = 32'sh7FFF_FFFF;
    end else begin
      deriv_sat = $signed(div_stat.quot[DATA_W-1:0]);
    end
  end

  // integrator sum, clamp bounds and final drive sum
  always_comb begin
    integ_sum = $signed({integral_r[DATA_W-1], integral_r})
              + $signed({step_r[DATA_W-1], step_r});
    lim_pos   = $signed({2'b00, limit_r});
    lim_neg   = -lim_pos;
    drive_sum = $signed({pd_r[HI_W], pd_r})
              + $signed({{(52 - DATA_W){integral_r[DATA_W-1]}}, integral_r});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser || (period_r == '0)) begin
            state_nxt = ST_OUT;
          end else if (first_r) begin
            state_nxt = ST_EP;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV:  if (div_stat.done) state_nxt = ST_EP;
      ST_EP:   state_nxt = ST_STEP;
      ST_STEP: state_nxt = ST_SG;
      ST_SG:   state_nxt = ST_INT;
      ST_INT:  state_nxt = ST_D;
      ST_D:    state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, divider start, multiplier operands
  always_comb begin
    in_tready        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {diff_mag, {FRAC_W{1'b0}}};
    div_req.divisor  = period_r;
    mul_a            = '0;
    mul_b            = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready     = 1'b1;
        div_req.start = in_tvalid && !in_tuser && (period_r != '0) && !first_r;
      end
      ST_EP: begin
        mul_a = $signed({err_r[DATA_W-1], err_r});
        mul_b = $signed({2'b00, period_r});
      end
      ST_STEP: begin
        mul_a = $signed({err_r[DATA_W-1], err_r});
        mul_b = $signed({prop_gain_r[DATA_W-1], prop_gain_r});
      end
      ST_SG: begin
        mul_a = $signed({step_r[DATA_W-1], step_r});
        mul_b = $signed({integ_gain_r[DATA_W-1], integ_gain_r});
      end
      ST_INT: begin
        mul_a = $signed({deriv_r[DATA_W-1], deriv_r});
        mul_b = $signed({deriv_gain_r[DATA_W-1], deriv_gain_r});
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      period_r     <= '0;
      limit_r      <= '0;
      enable_r     <= 1'b0;
      hold_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PROP_GAIN:  prop_gain_r  <= $signed(cfg_wdata);
        CFG_INTEG_GAIN: integ_gain_r <= $signed(cfg_wdata);
        CFG_DERIV_GAIN: deriv_gain_r <= $signed(cfg_wdata);
        CFG_PERIOD:     period_r     <= cfg_wdata[PER_W-1:0];
        CFG_LIMIT:      limit_r      <= cfg_wdata[PER_W-1:0];
        CFG_ENABLE:     enable_r     <= cfg_wdata[0];
        CFG_HOLD:       hold_r       <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  // sequencer state and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_error_r <= '0;
      last_drive_r <= '0;
      integral_r   <= '0;
      first_r      <= 1'b1;
      clamp_flag_r <= CLAMP_NONE;
    end else begin
      state_r <= state_nxt;
      // clear item returns the controller to its reset state
      if (in_xfer && in_tuser) begin
        last_error_r <= '0;
        last_drive_r <= '0;
        integral_r   <= '0;
        first_r      <= 1'b1;
        clamp_flag_r <= CLAMP_NONE;
      end
      // integrator update with symmetric clamp; cleared when disabled, kept on hold
      if (state_r == ST_D) begin
        if (!enable_r) begin
          integral_r <= '0;
        end else if (!hold_r) begin
          if (integ_sum > lim_pos) begin
            integral_r   <= lim_pos[DATA_W-1:0];
            clamp_flag_r <= CLAMP_HIGH;
          end else if (integ_sum < lim_neg) begin
            integral_r   <= lim_neg[DATA_W-1:0];
            clamp_flag_r <= CLAMP_LOW;
          end else begin
            integral_r   <= integ_sum[DATA_W-1:0];
            clamp_flag_r <= CLAMP_NONE;
          end
        end
      end
      // commit the step
      if (state_r == ST_SUM) begin
        last_error_r <= err_r;
        last_drive_r <= sat32(drive_sum);
        first_r      <= 1'b0;
      end
    end
  end

  // working datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      err_r   <= in_err;
      dneg_r  <= err_diff[DATA_W];
      deriv_r <= '0;
      if (in_tuser) begin
        res_drive_r <= '0;
        res_clamp_r <= CLAMP_NONE;
      end else begin
        res_drive_r <= last_drive_r;
        res_clamp_r <= clamp_flag_r;
      end
    end
    case (state_r)
      ST_DIV:  if (div_stat.done) deriv_r <= deriv_sat;
      ST_STEP: step_r <= prod_sat;
      ST_SG:   p_r <= prod_hi;
      ST_INT:  step_r <= prod_sat;
      ST_D:    pd_r <= $signed({p_r[HI_W-1], p_r}) + $signed({prod_hi[HI_W-1], prod_hi});
      ST_SUM: begin
        res_drive_r <= sat32(drive_sum);
        res_clamp_r <= clamp_flag_r;
      end
      default: ;
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == ST_OUT) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && out_free) begin
      out_drive_r <= res_drive_r;
      out_clamp_r <= res_clamp_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, out_clamp_r, out_drive_r};

  // the divider only runs while the sequencer waits on it
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == ST_DIV))
    else $error("divider busy outside the divide state");

  // a clear transfer yields a zero result next
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser) |=> ((state_r == ST_OUT) && (res_drive_r == '0)
                               && (res_clamp_r == CLAMP_NONE)))
    else $error("clear transfer did not produce a zero result");

  // no previous error is kept while waiting for the first sample
  a_first_no_history: assert property (@(posedge clk) disable iff (!rst_n)
    first_r |-> (last_error_r == '0))
    else $error("first sample pending with a stale previous error");

  // clamp flag never holds the unused code
  a_clamp_code: assert property (@(posedge clk) disable iff (!rst_n)
    (clamp_flag_r == CLAMP_NONE) || (clamp_flag_r == CLAMP_HIGH)
    || (clamp_flag_r == CLAMP_LOW))
    else $error("clamp flag holds an unused code");

endmodule

`default_nettype wire

/* design/pidc_div.sv */
// serial restoring divider, one quotient bit per cycle
`default_nettype none

module pidc_div import pidc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire div_req_t  req,
  output div_stat_t      stat
);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] dvs_r;

  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   trial_sub;
  logic              fits;
  logic [DIVS_W-1:0] rem_nxt;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial     = {rem_r, quo_r[DIVD_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    fits      = (trial >= {1'b0, dvs_r});
    rem_nxt   = fits ? trial_sub[DIVS_W-1:0] : trial[DIVS_W-1:0];
  end

  // control: busy flag, step counter, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIVD_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.quot = quo_r;

endmodule

`default_nettype wire

/* design/pidc_mul.sv */
// shared signed multiplier with registered product
`default_nettype none

module pidc_mul import pidc_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  op_a,
  input  wire logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0]      prod
);

  logic signed [PROD_W-1:0] prod_r;

  // one product per cycle, registered
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire
